/* rtl/core/wotp_pkg.sv */
package wotp_pkg;

    localparam logic [7:0]  NEXT_DAY_BIT     = 8'h80;
    localparam logic [7:0]  DAY_BIT_BASE     = 8'h01;
    localparam logic [5:0]  START_WINDOW_SEC = 6'd3;
    localparam logic [2:0]  LAST_WEEKDAY     = 3'd6;
    localparam logic        CMD_TICK         = 1'b0;
    localparam logic        CMD_REARM        = 1'b1;

    typedef enum logic [2:0] {
        REG_START_A = 3'd0,
        REG_STOP_A  = 3'd1,
        REG_MASK_A  = 3'd2,
        REG_REPEAT_A = 3'd3,
        REG_START_B = 3'd4,
        REG_STOP_B  = 3'd5,
        REG_MASK_B  = 3'd6,
        REG_REPEAT_B = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic       command;
        logic [2:0] day_of_week;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_in;

    typedef struct packed {
        logic       request_on;
        logic       request_off;
        logic [7:0] live_mask_a_out;
        logic [7:0] live_mask_b_out;
    } t_out;

    typedef struct packed {
        logic       on;
        logic       off;
        logic [7:0] live;
    } t_check;

endpackage

/* rtl/core/wotp_in_if.sv */
interface wotp_in_if
    import wotp_pkg::*;
;
    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/wotp_out_if.sv */
interface wotp_out_if
    import wotp_pkg::*;
;
    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/weekly_on_off_timer_pair_top.sv */
// Datapath: an accepted request is held in the input register, then its result in the result
// register, which holds it while the output is stalled.
// Throughput: one request per cycle; the input register and the result register both
// advance whenever the result register is empty or its data is being taken.
// Reset: synchronous, active low; clears both valid flags, all configuration
// registers and both live masks to zero.
module weekly_on_off_timer_pair_top
    import wotp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    wotp_in_if.sink            i_in,
    wotp_out_if.source         o_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [10:0]        i_cfg_wdata
);

    logic [10:0] r_start_a, r_stop_a, r_start_b, r_stop_b;
    logic [7:0]  r_mask_a, r_mask_b;
    logic        r_repeat_a, r_repeat_b;
    logic [7:0]  r_live_a, r_live_b;
    logic [7:0]  n_live_a, n_live_b;
    logic        r_s1_valid, r_out_valid;
    t_in         r_s1;
    t_out        r_out, n_out;
    logic        out_free, s1_adv;
    logic [10:0] now_min;
    t_check      chk_a, chk_b;

    function automatic t_check check_one(
        input logic [10:0] start,
        input logic [10:0] stop,
        input logic        rep,
        input logic [7:0]  live,
        input logic [2:0]  dow,
        input logic [10:0] now,
        input logic [5:0]  sec
    );
        logic [2:0] day;
        logic [7:0] day_bit;
        t_check     res;
        day = dow;
        if (stop < start && now <= stop) begin
            day = (dow == 3'd0) ? LAST_WEEKDAY : dow - 3'd1;
        end
        day_bit = (day <= LAST_WEEKDAY) ? (DAY_BIT_BASE << day) : 8'h00;
        res.on   = 1'b0;
        res.off  = 1'b0;
        res.live = live;
        if ((live & (day_bit | NEXT_DAY_BIT)) != 8'h00) begin
            res.on = (now == start) && (sec < START_WINDOW_SEC);
            if (now == stop) begin
                res.off = 1'b1;
                if (!rep) begin
                    if ((live & NEXT_DAY_BIT) != 8'h00) begin
                        res.live = 8'h00;
                    end else begin
                        res.live = live & ~day_bit;
                    end
                end
            end
        end
        return res;
    endfunction

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign now_min = 11'({r_s1.hour, 6'b0}) - 11'({r_s1.hour, 2'b0}) + 11'(r_s1.minute);

    always_comb begin
        chk_a = check_one(r_start_a, r_stop_a, r_repeat_a, r_live_a,
                          r_s1.day_of_week, now_min, r_s1.second);
        chk_b = check_one(r_start_b, r_stop_b, r_repeat_b, r_live_b,
                          r_s1.day_of_week, now_min, r_s1.second);
        if (r_s1.command == CMD_REARM) begin
            n_live_a          = r_mask_a;
            n_live_b          = r_mask_b;
            n_out.request_on  = 1'b0;
            n_out.request_off = 1'b0;
        end else begin
            n_live_a          = chk_a.live;
            n_live_b          = chk_b.live;
            n_out.request_on  = chk_a.on | chk_b.on;
            n_out.request_off = chk_a.off | chk_b.off;
        end
        n_out.live_mask_a_out = n_live_a;
        n_out.live_mask_b_out = n_live_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_a  <= '0;
            r_stop_a   <= '0;
            r_mask_a   <= '0;
            r_repeat_a <= 1'b0;
            r_start_b  <= '0;
            r_stop_b   <= '0;
            r_mask_b   <= '0;
            r_repeat_b <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_START_A:  r_start_a  <= i_cfg_wdata;
                REG_STOP_A:   r_stop_a   <= i_cfg_wdata;
                REG_MASK_A:   r_mask_a   <= i_cfg_wdata[7:0];
                REG_REPEAT_A: r_repeat_a <= i_cfg_wdata[0];
                REG_START_B:  r_start_b  <= i_cfg_wdata;
                REG_STOP_B:   r_stop_b   <= i_cfg_wdata;
                REG_MASK_B:   r_mask_b   <= i_cfg_wdata[7:0];
                REG_REPEAT_B: r_repeat_b <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_live_a    <= '0;
            r_live_b    <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_live_a <= n_live_a;
                r_live_b <= n_live_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1 <= i_in.data;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

endmodule

/* rtl/core/wotp_checker.sv */
module wotp_checker
    import wotp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    logic [7:0] r_prev_a, r_prev_b;
    logic       out_fire;

    assign out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= '0;
            r_prev_b <= '0;
        end else if (out_fire) begin
            r_prev_a <= i_out_data.live_mask_a_out;
            r_prev_b <= i_out_data.live_mask_b_out;
        end
    end

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    // a stop request never comes with a rearm, so masks may only lose bits
    a_stop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && i_out_data.request_off |->
            ((i_out_data.live_mask_a_out & ~r_prev_a) == 8'h00) &&
            ((i_out_data.live_mask_b_out & ~r_prev_b) == 8'h00))
        else $error("live mask gained bits on a stop request");

    a_start_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && i_out_data.request_on |-> (r_prev_a != 8'h00) || (r_prev_b != 8'h00))
        else $error("start request with both live masks empty");

endmodule

bind weekly_on_off_timer_pair_top wotp_checker u_wotp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* dv/weekly_on_off_timer_pair_top_tb.sv */
`timescale 1ns / 100ps

module weekly_on_off_timer_pair_top_tb;
    import wotp_pkg::*;

    localparam int          MIN_PER_HOUR = 60;
    localparam int          LAST_MINUTE  = 1439;
    localparam int          TOP_MINUTE   = 1919;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          N_DIRECTED   = 19;
    localparam int          N_PHASES     = 6;
    localparam int          N_PER_PHASE  = 110;
    localparam t_out        NO_RESULT    = '0;

    typedef struct packed {
        t_in  req;
        logic typed;
        t_out want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [10:0] i_cfg_wdata;

    wotp_in_if  in_if ();
    wotp_out_if out_if ();

    weekly_on_off_timer_pair_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [10:0] start_min [2];
    logic [10:0] stop_min  [2];
    logic [7:0]  prog_mask [2];
    logic [7:0]  live_mask [2];
    logic        weekly    [2];

    t_out awaiting [$];
    t_out want;
    int   mismatches;
    int   results_seen;
    int   cycles;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_left;

    // Each row: command, day, hour, minute, second; typed flag; expected on, off, A mask, B mask.
    t_dir_row dir_rows [N_DIRECTED] = '{
        '{{CMD_TICK,  3'd1, 5'd23, 6'd0,  6'd0},  1'b1, {1'b0, 1'b0, 8'h00, 8'h00}},
        '{{CMD_REARM, 3'd7, 5'd31, 6'd63, 6'd63}, 1'b1, {1'b0, 1'b0, 8'h03, 8'hC0}},
        '{{CMD_TICK,  3'd0, 5'd0,  6'd0,  6'd0},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd0, 5'd0,  6'd0,  6'd2},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd0, 5'd0,  6'd0,  6'd3},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd1, 5'd23, 6'd0,  6'd1},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd2, 5'd7,  6'd0,  6'd30}, 1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd2, 5'd7,  6'd0,  6'd0},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd1, 5'd7,  6'd0,  6'd59}, 1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd6, 5'd23, 6'd59, 6'd59}, 1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd7, 5'd0,  6'd0,  6'd0},  1'b0, NO_RESULT},
        '{{CMD_REARM, 3'd0, 5'd0,  6'd0,  6'd0},  1'b1, {1'b0, 1'b0, 8'h03, 8'hC0}},
        '{{CMD_TICK,  3'd7, 5'd0,  6'd0,  6'd1},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd5, 5'd31, 6'd63, 6'd63}, 1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd7, 5'd23, 6'd59, 6'd0},  1'b1, {1'b0, 1'b1, 8'h03, 8'h00}},
        '{{CMD_TICK,  3'd0, 5'd7,  6'd0,  6'd0},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd0, 5'd23, 6'd0,  6'd0},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd1, 5'd6,  6'd59, 6'd0},  1'b0, NO_RESULT},
        '{{CMD_TICK,  3'd1, 5'd7,  6'd1,  6'd0},  1'b0, NO_RESULT}
    };

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("weekly_on_off_timer_pair_top_tb: errors");
            $finish;
        end
    end

    function automatic t_out predict_result(input t_in req);
        t_out        res;
        int unsigned now_min;
        logic [2:0]  day;
        logic [7:0]  day_bit;
        res = '0;
        if (req.command == CMD_REARM) begin
            live_mask[0] = prog_mask[0];
            live_mask[1] = prog_mask[1];
        end else begin
            now_min = req.hour * MIN_PER_HOUR + req.minute;
            for (int t = 0; t < 2; t++) begin
                day = req.day_of_week;
                if (stop_min[t] < start_min[t] && now_min <= stop_min[t])
                    day = (day == 3'd0) ? LAST_WEEKDAY : day - 3'd1;
                day_bit = (day <= LAST_WEEKDAY) ? (DAY_BIT_BASE << day) : 8'h00;
                if ((live_mask[t] & (day_bit | NEXT_DAY_BIT)) != 8'h00) begin
                    if (now_min == start_min[t] && req.second < START_WINDOW_SEC)
                        res.request_on = 1'b1;
                    if (now_min == stop_min[t]) begin
                        res.request_off = 1'b1;
                        if (!weekly[t]) begin
                            if ((live_mask[t] & NEXT_DAY_BIT) != 8'h00)
                                live_mask[t] = 8'h00;
                            else
                                live_mask[t] = live_mask[t] & ~day_bit;
                        end
                    end
                end
            end
        end
        res.live_mask_a_out = live_mask[0];
        res.live_mask_b_out = live_mask[1];
        return res;
    endfunction

    function automatic logic [10:0] pick_minute();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'(LAST_MINUTE);
            2:       return 11'h7FF;
            3:       return 11'($urandom_range(LAST_MINUTE + 1, 2047));
            default: return 11'($urandom_range(0, LAST_MINUTE));
        endcase
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return NEXT_DAY_BIT;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in random_req();
        t_in         req;
        int unsigned target;
        int unsigned sel;
        req = '0;
        req.day_of_week = 3'($urandom_range(0, 7));
        req.second = $urandom_range(0, 1) ? 6'($urandom_range(0, 4)) : 6'($urandom_range(0, 63));
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            req.command = CMD_REARM;
            req.hour = 5'($urandom);
            req.minute = 6'($urandom);
        end else if (sel < 20) begin
            req.command = CMD_TICK;
            req.hour = 5'($urandom_range(0, 31));
            req.minute = 6'($urandom_range(0, 63));
        end else begin
            req.command = CMD_TICK;
            case ($urandom_range(0, 6))
                0:       target = start_min[0];
                1:       target = stop_min[0];
                2:       target = start_min[1];
                3:       target = stop_min[1];
                4:       target = start_min[$urandom_range(0, 1)] + $urandom_range(0, 2) - 1;
                5:       target = stop_min[$urandom_range(0, 1)] + $urandom_range(0, 2) - 1;
                default: target = $urandom_range(0, LAST_MINUTE);
            endcase
            if (target > TOP_MINUTE)
                target = $urandom_range(0, LAST_MINUTE);
            req.hour = 5'(target / MIN_PER_HOUR);
            req.minute = 6'(target % MIN_PER_HOUR);
        end
        return req;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic set_reg(input t_cfg_reg idx, input logic [10:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_START_A:  start_min[0] = val;
            REG_STOP_A:   stop_min[0]  = val;
            REG_MASK_A:   prog_mask[0] = val[7:0];
            REG_REPEAT_A: weekly[0]    = val[0];
            REG_START_B:  start_min[1] = val;
            REG_STOP_B:   stop_min[1]  = val;
            REG_MASK_B:   prog_mask[1] = val[7:0];
            REG_REPEAT_B: weekly[1]    = val[0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_timers(
        input logic [10:0] start_a, input logic [10:0] stop_a,
        input logic [7:0] mask_a, input logic rep_a,
        input logic [10:0] start_b, input logic [10:0] stop_b,
        input logic [7:0] mask_b, input logic rep_b
    );
        set_reg(REG_START_A,  start_a);
        set_reg(REG_STOP_A,   stop_a);
        set_reg(REG_MASK_A,   {3'($urandom), mask_a});
        set_reg(REG_REPEAT_A, {10'($urandom), rep_a});
        set_reg(REG_START_B,  start_b);
        set_reg(REG_STOP_B,   stop_b);
        set_reg(REG_MASK_B,   {3'($urandom), mask_b});
        set_reg(REG_REPEAT_B, {10'($urandom), rep_b});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_req(input t_in req, input logic typed, input t_out typed_res);
        t_out res;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= req;
        do @(posedge i_clk); while (!in_if.ready);
        res = predict_result(req);
        awaiting.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaiting.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (awaiting.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected: %h",
                                     results_seen, out_if.data));
            end else begin
                want = awaiting.pop_front();
                if (out_if.data.request_on !== want.request_on
                        || out_if.data.request_off !== want.request_off
                        || out_if.data.live_mask_a_out !== want.live_mask_a_out
                        || out_if.data.live_mask_b_out !== want.live_mask_b_out)
                    flag_error($sformatf(
                        "result %0d: want on=%0b off=%0b a=%02h b=%02h, got on=%0b off=%0b a=%02h b=%02h",
                        results_seen, want.request_on, want.request_off, want.live_mask_a_out,
                        want.live_mask_b_out, out_if.data.request_on, out_if.data.request_off,
                        out_if.data.live_mask_a_out, out_if.data.live_mask_b_out));
            end
        end
        if (hold_off_left > 0) begin
            out_if.ready <= 1'b0;
            hold_off_left--;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        t_in rearm;
        mismatches     = 0;
        results_seen   = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 0;
        start_min      = '{default: '0};
        stop_min       = '{default: '0};
        prog_mask      = '{default: '0};
        live_mask      = '{default: '0};
        weekly         = '{default: '0};
        rearm          = '0;
        rearm.command  = CMD_REARM;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Overnight one-shot on A; next-day one-shot on B
        program_timers(11'd1380, 11'd420, 8'h03, 1'b0, 11'd0, 11'd1439, 8'hC0, 1'b0);
        for (int r = 0; r < N_DIRECTED; r++)
            send_req(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);
        wait_drained();

        for (int phase = 1; phase <= N_PHASES; phase++) begin
            if (phase == 1)
                program_timers(11'd0, 11'd0, 8'hFF, 1'b0, 11'h7FF, 11'd1439, 8'h00, 1'b1);
            else
                program_timers(pick_minute(), pick_minute(), pick_mask(), 1'($urandom),
                               pick_minute(), pick_minute(), pick_mask(), 1'($urandom));
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            send_req(rearm, 1'b0, NO_RESULT);
            for (int n = 0; n < N_PER_PHASE; n++) begin
                // hold the result side off while requests keep coming
                if (phase == 3 && n == 30)
                    hold_off_left = 250;
                if (phase == 5 && n == 50)
                    wait_drained();
                send_req(random_req(), 1'b0, NO_RESULT);
            end
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("weekly_on_off_timer_pair_top_tb: clean");
        else
            $display("weekly_on_off_timer_pair_top_tb: errors");
        $finish;
    end

endmodule
